// File: hw/rtl/bmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmd_pkg: shared types and constants of the binary message deframer
// Holds the sync character, the message type table, the phase enum and
// the result record passed from the framing logic to the output register.
// ----------------------------------------------------------------------------
package bmd_pkg;

    localparam logic [7:0] SYNC_CHAR    = 8'h40;   // '@'
    localparam int         TYPE_NUM     = 19;
    localparam logic [4:0] TYPE_UNKNOWN = 5'd19;
    localparam logic [8:0] UNKNOWN_LEN  = 9'd7;

    typedef enum logic [1:0] {
        BMD_HUNT  = 2'd0,
        BMD_SYNC  = 2'd1,
        BMD_FRAME = 2'd2
    } bmd_phase_t;

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [8:0] len;
    } bmd_type_entry_t;

    localparam bmd_type_entry_t TYPE_TABLE [0:TYPE_NUM-1] = '{
        '{8'h41, 8'h61, 9'd10},  '{8'h41, 8'h62, 9'd10},  '{8'h41, 8'h63, 9'd11},
        '{8'h41, 8'h64, 9'd11},  '{8'h41, 8'h65, 9'd11},  '{8'h41, 8'h66, 9'd15},
        '{8'h41, 8'h73, 9'd20},  '{8'h41, 8'h74, 9'd8},   '{8'h41, 8'h77, 9'd8},
        '{8'h41, 8'h7a, 9'd11},  '{8'h42, 8'h6a, 9'd8},   '{8'h43, 8'h62, 9'd33},
        '{8'h43, 8'h66, 9'd7},   '{8'h43, 8'h68, 9'd9},   '{8'h43, 8'h6a, 9'd294},
        '{8'h45, 8'h61, 9'd76},  '{8'h45, 8'h6e, 9'd69},  '{8'h46, 8'h61, 9'd9},
        '{8'h53, 8'h7a, 9'd8}
    };

    typedef struct packed {
        logic [7:0] data_out;
        logic       in_frame;
        logic [8:0] byte_position;
        logic [4:0] type_code;
        logic       frame_start;
        logic       frame_last;
        logic       checksum_ok;
    } bmd_result_t;

endpackage

// File: hw/rtl/bmd_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmd_byte_if: received byte channel
// Valid/ready channel carrying one serial byte per transaction.
// ----------------------------------------------------------------------------
interface bmd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

// File: hw/rtl/bmd_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmd_result_if: deframed byte channel
// Valid/ready channel carrying the echoed byte and its framing marks.
// ----------------------------------------------------------------------------
interface bmd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       in_frame;
    logic [8:0] byte_position;
    logic [4:0] type_code;
    logic       frame_start;
    logic       frame_last;
    logic       checksum_ok;

    modport source (
        output valid, output data_out, output in_frame, output byte_position,
        output type_code, output frame_start, output frame_last,
        output checksum_ok, input ready
    );
    modport sink (
        input valid, input data_out, input in_frame, input byte_position,
        input type_code, input frame_start, input frame_last,
        input checksum_ok, output ready
    );
endinterface

// File: hw/rtl/binary_message_deframer_xor_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_message_deframer_xor_check: '@@'-synced message deframer
// Echoes each received byte with its frame position, type code and
// start, last and checksum marks.
// ----------------------------------------------------------------------------
// Usage:
//   serial    - sink channel, one received byte per transaction.
//   deframed  - source channel, one marked byte per transaction, in order.
//   Every accepted byte yields exactly one deframed transaction.
// Path: a taken byte is registered in the input stage, run through the
//   framing logic when it advances and lands in the output register,
//   whose valid flag then presents it on the deframed channel.
// Throughput: one byte per cycle unless ready drops. The type lookup is a
//   parallel compare of all 19 table entries; no byte needs a second pass.
// Stall: the input register and the output register are separate stages;
//   a new byte is still taken while a finished result waits, and ready
//   drops only when both stages are full and the receiver holds off.
// Reset: rst_n clears the stage valid flags and puts the framer in hunt
//   with position 0, length 7 and type unknown.
// ----------------------------------------------------------------------------
module binary_message_deframer_xor_check (
    input  logic          clk,
    input  logic          rst_n,
    bmd_byte_if.sink      serial,
    bmd_result_if.source  deframed
);

    logic                 stage_valid_reg;
    logic [7:0]           stage_byte_reg;
    logic                 out_valid_reg;
    bmd_pkg::bmd_result_t out_data_reg;
    bmd_pkg::bmd_result_t result;
    logic                 advance;
    logic                 in_take;

    // move the staged byte forward when the output register is free or drains
    assign advance      = stage_valid_reg && (!out_valid_reg || deframed.ready);
    assign serial.ready = !stage_valid_reg || advance;
    assign in_take      = serial.valid && serial.ready;

    bmd_frame_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (stage_byte_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (deframed.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: hold until the next transaction
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_byte_reg <= serial.byte_in;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign deframed.valid         = out_valid_reg;
    assign deframed.data_out      = out_data_reg.data_out;
    assign deframed.in_frame      = out_data_reg.in_frame;
    assign deframed.byte_position = out_data_reg.byte_position;
    assign deframed.type_code     = out_data_reg.type_code;
    assign deframed.frame_start   = out_data_reg.frame_start;
    assign deframed.frame_last    = out_data_reg.frame_last;
    assign deframed.checksum_ok   = out_data_reg.checksum_ok;

    // a byte taken while the stage is full must leave the stage the same cycle
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && stage_valid_reg) |-> advance)
        else $error("input stage overrun");

    // a frame start is always the first sync byte at position zero
    a_start_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (deframed.valid && deframed.frame_start) |->
        (deframed.in_frame && deframed.byte_position == 9'd0 &&
         deframed.data_out == bmd_pkg::SYNC_CHAR && !deframed.frame_last))
        else $error("bad frame start marks");

    // the last byte lies inside a frame past the type bytes
    a_last_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (deframed.valid && deframed.frame_last) |->
        (deframed.in_frame && deframed.byte_position >= 9'd6))
        else $error("bad frame last marks");

    // checksum status only appears on a frame's last byte
    a_ok_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (deframed.valid && deframed.checksum_ok) |-> deframed.frame_last)
        else $error("checksum_ok outside last byte");

endmodule

// File: hw/rtl/bmd_type_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmd_type_lookup: message type decoder
// Compares the two type characters against every table entry in parallel
// and returns the table index and total frame length.
// ----------------------------------------------------------------------------
module bmd_type_lookup (
    input  logic [7:0] c0,
    input  logic [7:0] c1,
    output logic [4:0] type_index,
    output logic [8:0] type_length
);

    always_comb
    begin
        type_index  = bmd_pkg::TYPE_UNKNOWN;
        type_length = bmd_pkg::UNKNOWN_LEN;
        // scan downward so the lowest matching entry wins
        for (int m = bmd_pkg::TYPE_NUM - 1; m >= 0; m--)
        begin
            if (bmd_pkg::TYPE_TABLE[m].c0 == c0 && bmd_pkg::TYPE_TABLE[m].c1 == c1)
            begin
                type_index  = 5'(m);
                type_length = bmd_pkg::TYPE_TABLE[m].len;
            end
        end
    end

endmodule

// File: hw/rtl/bmd_frame_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmd_frame_fsm: sync hunt, position count and checksum
// Holds the framing state, marks each byte and advances on every step.
// ----------------------------------------------------------------------------
module bmd_frame_fsm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          byte_in,
    output bmd_pkg::bmd_result_t result
);

    bmd_pkg::bmd_phase_t phase_reg, phase_next;
    logic [8:0] pos_reg,   pos_next;
    logic [8:0] len_reg,   len_next;
    logic [7:0] first_reg, first_next;
    logic [4:0] idx_reg,   idx_next;
    logic [7:0] xor_reg,   xor_next;
    logic       match_reg, match_next;

    logic [4:0] lk_index;
    logic [8:0] lk_length;
    logic       is_sync;
    logic       pos_two;
    logic       pos_three;
    logic       pos_ge3;
    logic [8:0] eff_len;
    logic [4:0] eff_idx;
    logic       is_last;
    logic       in_body;
    logic       is_check;

    bmd_type_lookup u_lookup (
        .c0          (first_reg),
        .c1          (byte_in),
        .type_index  (lk_index),
        .type_length (lk_length)
    );

    assign is_sync   = (byte_in == bmd_pkg::SYNC_CHAR);
    assign pos_two   = (pos_reg == 9'd2);
    assign pos_three = (pos_reg == 9'd3);
    assign pos_ge3   = (pos_reg >= 9'd3);
    assign eff_len   = pos_three ? lk_length : len_reg;
    assign eff_idx   = pos_three ? lk_index  : idx_reg;
    assign is_last   = pos_ge3 && ({1'b0, pos_reg} + 10'd1 >= {1'b0, eff_len});
    assign in_body   = ({1'b0, pos_reg} + 10'd4 <= {1'b0, len_reg});
    assign is_check  = ({1'b0, pos_reg} + 10'd3 == {1'b0, len_reg});

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            bmd_pkg::BMD_HUNT:  phase_next = is_sync ? bmd_pkg::BMD_SYNC : bmd_pkg::BMD_HUNT;
            bmd_pkg::BMD_SYNC:  phase_next = is_sync ? bmd_pkg::BMD_FRAME : bmd_pkg::BMD_HUNT;
            bmd_pkg::BMD_FRAME: phase_next = is_last ? bmd_pkg::BMD_HUNT : bmd_pkg::BMD_FRAME;
            default:            phase_next = bmd_pkg::BMD_HUNT;
        endcase
    end

    // datapath state and per-byte marks
    always_comb
    begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        first_next = first_reg;
        idx_next   = idx_reg;
        xor_next   = xor_reg;
        match_next = match_reg;

        result               = '0;
        result.data_out      = byte_in;
        result.type_code     = bmd_pkg::TYPE_UNKNOWN;

        case (phase_reg)
            bmd_pkg::BMD_HUNT:
            begin
                if (is_sync)
                begin
                    result.in_frame    = 1'b1;
                    result.frame_start = 1'b1;
                    pos_next   = 9'd1;
                    len_next   = bmd_pkg::UNKNOWN_LEN;
                    idx_next   = bmd_pkg::TYPE_UNKNOWN;
                    first_next = '0;
                    xor_next   = '0;
                    match_next = 1'b0;
                end
            end
            bmd_pkg::BMD_SYNC:
            begin
                if (is_sync)
                begin
                    result.in_frame      = 1'b1;
                    result.byte_position = 9'd1;
                    pos_next = 9'd2;
                end
                else
                begin
                    pos_next = '0;
                end
            end
            bmd_pkg::BMD_FRAME:
            begin
                result.in_frame      = 1'b1;
                result.byte_position = pos_reg;
                if (pos_two)
                begin
                    first_next = byte_in;
                    xor_next   = byte_in;
                end
                else if (pos_three)
                begin
                    idx_next = lk_index;
                    len_next = lk_length;
                    xor_next = xor_reg ^ byte_in;
                end
                else if (in_body)
                begin
                    xor_next = xor_reg ^ byte_in;
                end
                else if (is_check)
                begin
                    match_next = (xor_reg == byte_in);
                end
                if (pos_ge3)
                begin
                    result.type_code = eff_idx;
                end
                if (is_last)
                begin
                    result.frame_last  = 1'b1;
                    result.checksum_ok = match_reg;
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + 9'd1;
                end
            end
            default:
            begin
                pos_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bmd_pkg::BMD_HUNT;
            pos_reg   <= '0;
            len_reg   <= bmd_pkg::UNKNOWN_LEN;
            first_reg <= '0;
            idx_reg   <= bmd_pkg::TYPE_UNKNOWN;
            xor_reg   <= '0;
            match_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            first_reg <= first_next;
            idx_reg   <= idx_next;
            xor_reg   <= xor_next;
            match_reg <= match_next;
        end
    end

endmodule
